>>> sv/hmts_pkg.sv
package hmts_pkg;

   localparam int MAX_VERTS   = 256;
   localparam int CELL_W      = 8;
   localparam int VERTS_W     = 9;
   localparam int SHIFT_W     = 3;
   localparam int SCALE_W     = 16;
   localparam int SAMPLE_W    = 8;
   localparam int POS_IN_W    = 23;
   localparam int POS_W       = 24;
   localparam int HEIGHT_W    = 16;
   localparam int FRAC_W      = 9;
   localparam int ADDR_W      = 16;
   localparam int BANK_W      = ADDR_W - 1;
   localparam int BANK_DEPTH  = 1 << BANK_W;
   localparam int OUT_W       = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTS_ROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTS_COL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SHIFT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_SCALE = 2'd3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 9'd256;

   typedef struct packed {
      logic [VERTS_W-1:0] nr;
      logic [VERTS_W-1:0] nc;
      logic [SHIFT_W-1:0] shift;
      logic [SCALE_W-1:0] scale;
   } cfg_type;

   typedef struct packed {
      logic                query;
      logic [ADDR_W-1:0]   addr_a;
      logic [ADDR_W-1:0]   addr_c;
      logic [HEIGHT_W-1:0] data;
      logic [FRAC_W-1:0]   dx;
      logic [FRAC_W-1:0]   dz;
      logic                clip;
   } work_type;

endpackage

>>> sv/hmts_front.sv
module hmts_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [hmts_pkg::CELL_W-1:0]         req_row,
   input  logic [hmts_pkg::CELL_W-1:0]         req_col,
   input  logic [hmts_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic signed [hmts_pkg::POS_IN_W-1:0] req_x_pos,
   input  logic signed [hmts_pkg::POS_IN_W-1:0] req_z_pos,
   input  hmts_pkg::cfg_type                   cfg,
   input  logic                                queue_full,
   output logic                                push_valid,
   output hmts_pkg::work_type                  push_word
);

   typedef struct packed {
      logic [hmts_pkg::CELL_W-1:0] node;
      logic [hmts_pkg::FRAC_W-1:0] frac;
      logic                        clip;
   } axis_type;

   // scaled coordinate to grid node and fraction, clamped to the last cell
   function automatic axis_type split_axis(input logic signed [hmts_pkg::POS_W-1:0] pos,
                                           input logic [hmts_pkg::VERTS_W-1:0] n,
                                           input logic [hmts_pkg::SHIFT_W-1:0] sh);
      logic [hmts_pkg::VERTS_W-1:0] nm1;
      logic [15:0]                  limit;
      logic [hmts_pkg::POS_W-2:0]   shifted;
      logic [15:0]                  t;
      axis_type                     r;
      nm1     = n - 9'd1;
      limit   = {nm1[7:0], 8'd0};
      shifted = pos[hmts_pkg::POS_W-2:0] >> sh;
      r.clip  = 1'b0;
      if (pos[hmts_pkg::POS_W-1]) begin
         t      = '0;
         r.clip = 1'b1;
      end else if (shifted > 23'(limit)) begin
         t      = limit;
         r.clip = 1'b1;
      end else begin
         t = shifted[15:0];
      end
      if (t[15:8] == nm1[7:0]) begin
         r.node = nm1[7:0] - 8'd1;
         r.frac = hmts_pkg::FRAC_ONE;
      end else begin
         r.node = t[15:8];
         r.frac = {1'b0, t[7:0]};
      end
      return r;
   endfunction

   logic front_move;

   // stage 1: scale multiply, centring
   logic                                 f1_valid_ff;
   logic                                 f1_query_ff;
   logic [hmts_pkg::CELL_W-1:0]          f1_row_ff;
   logic [hmts_pkg::CELL_W-1:0]          f1_col_ff;
   logic [hmts_pkg::HEIGHT_W-1:0]        f1_data_ff;
   logic signed [hmts_pkg::POS_W-1:0]    f1_pos_x_ff;
   logic signed [hmts_pkg::POS_W-1:0]    f1_pos_z_ff;
   logic [23:0]                          scale_prod;
   logic [21:0]                          half_w;
   logic [21:0]                          half_d;
   logic signed [hmts_pkg::POS_W-1:0]    f1_pos_x_in;
   logic signed [hmts_pkg::POS_W-1:0]    f1_pos_z_in;

   // stage 2: split into node and fraction
   logic                                 f2_valid_ff;
   logic                                 f2_query_ff;
   logic [hmts_pkg::CELL_W-1:0]          f2_row_ff;
   logic [hmts_pkg::CELL_W-1:0]          f2_col_ff;
   logic [hmts_pkg::HEIGHT_W-1:0]        f2_data_ff;
   logic [hmts_pkg::FRAC_W-1:0]          f2_dx_ff;
   logic [hmts_pkg::FRAC_W-1:0]          f2_dz_ff;
   logic                                 f2_clip_ff;
   axis_type                             axis_x;
   axis_type                             axis_z;

   // stage 3: linear address
   logic                                 f3_valid_ff;
   hmts_pkg::work_type                   f3_word_ff;
   logic                                 f3_valid_in;
   hmts_pkg::work_type                   f3_word_in;
   logic [16:0]                          row_base;
   logic [16:0]                          addr_a;
   logic [16:0]                          addr_c;
   logic                                 in_range;

   assign front_move = !(f3_valid_ff && queue_full);
   assign req_stall  = !front_move;
   assign push_valid = f3_valid_ff && !queue_full;
   assign push_word  = f3_word_ff;

   always_comb begin
      scale_prod  = 24'(req_sample) * 24'(cfg.scale);
      half_w      = 22'({cfg.nr - 9'd1, 7'd0}) << cfg.shift;
      half_d      = 22'({cfg.nc - 9'd1, 7'd0}) << cfg.shift;
      f1_pos_x_in = $signed({2'b00, half_w}) + $signed({req_x_pos[hmts_pkg::POS_IN_W-1], req_x_pos});
      f1_pos_z_in = $signed({2'b00, half_d}) - $signed({req_z_pos[hmts_pkg::POS_IN_W-1], req_z_pos});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (front_move) begin
         f1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_move) begin
         f1_query_ff <= req_command == hmts_pkg::CMD_QUERY;
         f1_row_ff   <= req_row;
         f1_col_ff   <= req_col;
         f1_data_ff  <= scale_prod[23:8];
         f1_pos_x_ff <= f1_pos_x_in;
         f1_pos_z_ff <= f1_pos_z_in;
      end
   end

   always_comb begin
      axis_x = split_axis(f1_pos_x_ff, cfg.nr, cfg.shift);
      axis_z = split_axis(f1_pos_z_ff, cfg.nc, cfg.shift);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (front_move) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_move) begin
         f2_query_ff <= f1_query_ff;
         f2_row_ff   <= f1_query_ff ? axis_z.node : f1_row_ff;
         f2_col_ff   <= f1_query_ff ? axis_x.node : f1_col_ff;
         f2_data_ff  <= f1_data_ff;
         f2_dx_ff    <= axis_x.frac;
         f2_dz_ff    <= axis_z.frac;
         f2_clip_ff  <= axis_x.clip || axis_z.clip;
      end
   end

   always_comb begin
      row_base = 17'(f2_row_ff) * 17'(cfg.nr);
      addr_a   = row_base + 17'(f2_col_ff);
      addr_c   = row_base + 17'(f2_col_ff) + 17'(cfg.nr);
      in_range = (9'(f2_row_ff) < cfg.nc) && (9'(f2_col_ff) < cfg.nr);
      // loads beyond the grid are dropped here
      f3_valid_in       = f2_valid_ff && (f2_query_ff || in_range);
      f3_word_in.query  = f2_query_ff;
      f3_word_in.addr_a = addr_a[hmts_pkg::ADDR_W-1:0];
      f3_word_in.addr_c = addr_c[hmts_pkg::ADDR_W-1:0];
      f3_word_in.data   = f2_data_ff;
      f3_word_in.dx     = f2_dx_ff;
      f3_word_in.dz     = f2_dz_ff;
      f3_word_in.clip   = f2_clip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else if (front_move) begin
         f3_valid_ff <= f3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (front_move) begin
         f3_word_ff <= f3_word_in;
      end
   end

endmodule

>>> sv/hmts_queue.sv
module hmts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  hmts_pkg::work_type push_word,
   input  logic               pop,
   output logic               head_valid,
   output hmts_pkg::work_type head_word,
   output logic               full
);

   hmts_pkg::work_type              slots_ff [hmts_pkg::QUEUE_DEPTH];
   logic [hmts_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [hmts_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [hmts_pkg::QCNT_W-1:0]     count_ff;
   logic [hmts_pkg::QCNT_W-1:0]     count_in;
   logic                            do_pop;

   assign full       = count_ff == hmts_pkg::QCNT_W'(hmts_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_word  = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 3'd1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> sv/hmts_back.sv
module hmts_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  hmts_pkg::work_type            head_word,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hmts_pkg::OUT_W-1:0]    rsp_height,
   output logic                          rsp_clamped
);

   // two copies of the store, each split into even and odd addresses:
   // one copy serves corners a and b, the other c and d
   logic [hmts_pkg::HEIGHT_W-1:0] ab_even_mem [hmts_pkg::BANK_DEPTH];
   logic [hmts_pkg::HEIGHT_W-1:0] ab_odd_mem  [hmts_pkg::BANK_DEPTH];
   logic [hmts_pkg::HEIGHT_W-1:0] cd_even_mem [hmts_pkg::BANK_DEPTH];
   logic [hmts_pkg::HEIGHT_W-1:0] cd_odd_mem  [hmts_pkg::BANK_DEPTH];
   logic [hmts_pkg::HEIGHT_W-1:0] ab_even_q;
   logic [hmts_pkg::HEIGHT_W-1:0] ab_odd_q;
   logic [hmts_pkg::HEIGHT_W-1:0] cd_even_q;
   logic [hmts_pkg::HEIGHT_W-1:0] cd_odd_q;

   logic                          back_move;
   logic                          do_write;
   logic                          do_read;
   logic [hmts_pkg::BANK_W-1:0]   wr_idx;
   logic [hmts_pkg::BANK_W-1:0]   ab_even_idx;
   logic [hmts_pkg::BANK_W-1:0]   ab_odd_idx;
   logic [hmts_pkg::BANK_W-1:0]   cd_even_idx;
   logic [hmts_pkg::BANK_W-1:0]   cd_odd_idx;

   logic                          b1_valid_ff;
   logic [hmts_pkg::FRAC_W-1:0]   b1_dx_ff;
   logic [hmts_pkg::FRAC_W-1:0]   b1_dz_ff;
   logic                          b1_clip_ff;
   logic                          b1_swap_ab_ff;
   logic                          b1_swap_cd_ff;

   logic [hmts_pkg::HEIGHT_W-1:0] ha;
   logic [hmts_pkg::HEIGHT_W-1:0] hb;
   logic [hmts_pkg::HEIGHT_W-1:0] hc;
   logic [hmts_pkg::HEIGHT_W-1:0] hd;
   logic                          lower;
   logic [hmts_pkg::HEIGHT_W-1:0] base_in;
   logic signed [16:0]            p_diff;
   logic signed [16:0]            q_diff;
   logic [hmts_pkg::FRAC_W-1:0]   w1;
   logic [hmts_pkg::FRAC_W-1:0]   w2;
   logic signed [26:0]            p1_in;
   logic signed [26:0]            p2_in;

   logic                          b2_valid_ff;
   logic [hmts_pkg::HEIGHT_W-1:0] b2_base_ff;
   logic signed [26:0]            b2_p1_ff;
   logic signed [26:0]            b2_p2_ff;
   logic                          b2_clip_ff;

   logic signed [27:0]            sum;
   logic [hmts_pkg::OUT_W-1:0]    height_in;

   logic                          rsp_valid_ff;
   logic [hmts_pkg::OUT_W-1:0]    rsp_height_ff;
   logic                          rsp_clamped_ff;

   assign back_move   = !(rsp_valid_ff && rsp_stall);
   assign pop         = back_move && head_valid;
   assign do_write    = pop && !head_word.query;
   assign do_read     = pop && head_word.query;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_height  = rsp_height_ff;
   assign rsp_clamped = rsp_clamped_ff;

   // a pair at addr and addr+1 always lands in opposite banks
   always_comb begin
      wr_idx      = head_word.addr_a[hmts_pkg::ADDR_W-1:1];
      ab_odd_idx  = head_word.addr_a[hmts_pkg::ADDR_W-1:1];
      ab_even_idx = head_word.addr_a[hmts_pkg::ADDR_W-1:1] + 15'(head_word.addr_a[0]);
      cd_odd_idx  = head_word.addr_c[hmts_pkg::ADDR_W-1:1];
      cd_even_idx = head_word.addr_c[hmts_pkg::ADDR_W-1:1] + 15'(head_word.addr_c[0]);
   end

   always_ff @(posedge clock) begin
      if (do_write && !head_word.addr_a[0]) begin
         ab_even_mem[wr_idx] <= head_word.data;
      end
      if (do_read) begin
         ab_even_q <= ab_even_mem[ab_even_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write && head_word.addr_a[0]) begin
         ab_odd_mem[wr_idx] <= head_word.data;
      end
      if (do_read) begin
         ab_odd_q <= ab_odd_mem[ab_odd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write && !head_word.addr_a[0]) begin
         cd_even_mem[wr_idx] <= head_word.data;
      end
      if (do_read) begin
         cd_even_q <= cd_even_mem[cd_even_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (do_write && head_word.addr_a[0]) begin
         cd_odd_mem[wr_idx] <= head_word.data;
      end
      if (do_read) begin
         cd_odd_q <= cd_odd_mem[cd_odd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (back_move) begin
         b1_valid_ff  <= do_read;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (back_move) begin
         b1_dx_ff      <= head_word.dx;
         b1_dz_ff      <= head_word.dz;
         b1_clip_ff    <= head_word.clip;
         b1_swap_ab_ff <= head_word.addr_a[0];
         b1_swap_cd_ff <= head_word.addr_c[0];
      end
   end

   always_comb begin
      ha    = b1_swap_ab_ff ? ab_odd_q : ab_even_q;
      hb    = b1_swap_ab_ff ? ab_even_q : ab_odd_q;
      hc    = b1_swap_cd_ff ? cd_odd_q : cd_even_q;
      hd    = b1_swap_cd_ff ? cd_even_q : cd_odd_q;
      lower = (10'(b1_dx_ff) + 10'(b1_dz_ff)) < 10'd256;
      if (lower) begin
         base_in = ha;
         p_diff  = $signed({1'b0, hb}) - $signed({1'b0, ha});
         q_diff  = $signed({1'b0, hc}) - $signed({1'b0, ha});
         w1      = b1_dx_ff;
         w2      = b1_dz_ff;
      end else begin
         // upper triangle, weights taken from the far corner
         base_in = hd;
         p_diff  = $signed({1'b0, hc}) - $signed({1'b0, hd});
         q_diff  = $signed({1'b0, hb}) - $signed({1'b0, hd});
         w1      = hmts_pkg::FRAC_ONE - b1_dx_ff;
         w2      = hmts_pkg::FRAC_ONE - b1_dz_ff;
      end
      p1_in = p_diff * $signed({1'b0, w1});
      p2_in = q_diff * $signed({1'b0, w2});
   end

   always_ff @(posedge clock) begin
      if (back_move) begin
         b2_base_ff <= base_in;
         b2_p1_ff   <= p1_in;
         b2_p2_ff   <= p2_in;
         b2_clip_ff <= b1_clip_ff;
      end
   end

   always_comb begin
      sum = $signed({4'b0000, b2_base_ff, 8'd0}) + $signed({b2_p1_ff[26], b2_p1_ff})
            + $signed({b2_p2_ff[26], b2_p2_ff});
      if (sum[27]) begin
         height_in = '0;
      end else if (sum[26:24] != 3'd0) begin
         height_in = '1;
      end else begin
         height_in = sum[hmts_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (back_move) begin
         rsp_height_ff  <= height_in;
         rsp_clamped_ff <= b2_clip_ff;
      end
   end

endmodule

>>> sv/heightmap_triangle_height_sampler.sv
// a query word passes the front registers f1, f2, f3, a queue slot, then b1, b2 and rsp
// throughput: one word per cycle while nothing stalls; the four corner heights come
// from a store kept in two copies of even/odd banks, one read port each, all read together
// a queue of 4 words between front and back lets either side stall on its own
// reset clears the valid flags, the queue and the registers to their reset values;
// the height store is not cleared and holds no meaning until loaded
module heightmap_triangle_height_sampler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [hmts_pkg::CELL_W-1:0]          req_row,
   input  logic [hmts_pkg::CELL_W-1:0]          req_col,
   input  logic [hmts_pkg::SAMPLE_W-1:0]        req_sample,
   input  logic signed [hmts_pkg::POS_IN_W-1:0] req_x_pos,
   input  logic signed [hmts_pkg::POS_IN_W-1:0] req_z_pos,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [hmts_pkg::OUT_W-1:0]           rsp_height,
   output logic                                 rsp_clamped,
   input  logic                                 csr_write,
   input  logic [hmts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hmts_pkg::SCALE_W-1:0]         csr_wdata
);

   logic [hmts_pkg::VERTS_W-1:0] verts_row_ff;
   logic [hmts_pkg::VERTS_W-1:0] verts_col_ff;
   logic [hmts_pkg::SHIFT_W-1:0] tile_shift_ff;
   logic [hmts_pkg::SCALE_W-1:0] height_scale_ff;
   hmts_pkg::cfg_type            cfg;

   logic                         queue_full;
   logic                         push_valid;
   hmts_pkg::work_type           push_word;
   logic                         head_valid;
   hmts_pkg::work_type           head_word;
   logic                         pop;

   function automatic logic [hmts_pkg::VERTS_W-1:0] sat_verts(
      input logic [hmts_pkg::VERTS_W-1:0] v);
      logic [hmts_pkg::VERTS_W-1:0] r;
      if (v < 9'd2) begin
         r = 9'd2;
      end else if (v > 9'(hmts_pkg::MAX_VERTS)) begin
         r = 9'(hmts_pkg::MAX_VERTS);
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         verts_row_ff    <= 9'd256;
         verts_col_ff    <= 9'd256;
         tile_shift_ff   <= 3'd1;
         height_scale_ff <= 16'd128;
      end else if (csr_write) begin
         unique case (csr_index)
            hmts_pkg::CSR_VERTS_ROW:    verts_row_ff    <= csr_wdata[hmts_pkg::VERTS_W-1:0];
            hmts_pkg::CSR_VERTS_COL:    verts_col_ff    <= csr_wdata[hmts_pkg::VERTS_W-1:0];
            hmts_pkg::CSR_TILE_SHIFT:   tile_shift_ff   <= csr_wdata[hmts_pkg::SHIFT_W-1:0];
            hmts_pkg::CSR_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      cfg.nr    = sat_verts(verts_row_ff);
      cfg.nc    = sat_verts(verts_col_ff);
      cfg.shift = tile_shift_ff;
      cfg.scale = height_scale_ff;
   end

   hmts_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_sample  (req_sample),
      .req_x_pos   (req_x_pos),
      .req_z_pos   (req_z_pos),
      .cfg         (cfg),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_word   (push_word)
   );

   hmts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word),
      .full       (queue_full)
   );

   hmts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_word   (head_word),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_height  (rsp_height),
      .rsp_clamped (rsp_clamped)
   );

endmodule

>>> sv/hmts_checker.sv
module hmts_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [hmts_pkg::OUT_W-1:0]           rsp_height,
   input logic                                 rsp_clamped
);

   // nothing in flight and nothing refused straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // the input side only backs up once the result side has refused a word
   assert property (@(posedge clock) disable iff (reset)
                    $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without output back-pressure");

   // a held result word keeps its payload
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_height)
                    && $stable(rsp_clamped))
      else $error("stalled result word changed");

   // a result word never appears straight out of reset: output needs a prior accept
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid) |-> !$past(reset))
      else $error("result word appeared straight out of reset");

   // an offered input word stays offered until it is taken
   assert property (@(posedge clock) disable iff (reset)
                    req_valid && req_stall |=> req_valid)
      else $error("input word withdrawn while stalled");

endmodule

bind heightmap_triangle_height_sampler hmts_checker u_hmts_checker (.*);
